>>> hdl/cfsm_pkg.sv
// Shared types, constants and byte helpers for the case-folding substring matcher.
// No dependencies; imported by every module of the block.
`default_nettype none

package cfsm_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_PATTERN_DEF = 8;
  localparam int TEXT_MAX_DEF    = 256;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;

  // Result queue between the matcher and the output channel.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES  = 3'd0,
    REG_PATTERN_LENGTH = 3'd1,
    REG_START_POSITION = 3'd2,
    REG_FOLD_CASE      = 3'd3,
    REG_REPORT_ALL     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic       closing;
    logic       found;
    logic [7:0] match_start;
  } result_t;

  // ASCII upper-case letters map to lower case when folding is on.
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    if (en && c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  // Pattern character j; characters beyond the eighth read as zero.
  function automatic logic [7:0] pattern_at(input logic [63:0] p, input logic [5:0] j);
    if (j > 6'd7) begin
      return 8'h00;
    end
    return p[{j[2:0], 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

>>> hdl/cfsm_match_unit.sv
// Parallel compare of the sliding text window against the configured pattern.
// Depends on cfsm_pkg for the case folding and pattern byte helpers.
`default_nettype none

module cfsm_match_unit import cfsm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
  input  wire logic [MAX_PATTERN-1:0][7:0] win,        // entry 0 is the newest byte
  input  wire logic [63:0]                 pattern_bytes,
  input  wire logic [IDX_W-1:0]            len_m1,     // effective pattern length minus one
  input  wire logic                        fold_case,
  output logic                             hit
);

  logic [IDX_W-1:0] idx;
  logic [7:0]       pb;

  // Window entry k lines up with pattern character len-1-k.
  always_comb begin
    hit = 1'b1;
    idx = '0;
    pb  = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (IDX_W'(k) <= len_m1) begin
        idx = len_m1 - IDX_W'(k);
        pb  = pattern_at(pattern_bytes, 6'(idx));
        if (fold_byte(win[k], fold_case) != fold_byte(pb, fold_case)) begin
          hit = 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/cfsm_out_queue.sv
// Small result queue taking up to two results a cycle and giving one a beat.
// Depends on cfsm_pkg for the result type and queue sizes.
`default_nettype none

module cfsm_out_queue import cfsm_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push0,     // first result of the item
  input  wire result_t entry0,
  input  wire logic    push1,     // second result, queued behind the first
  input  wire result_t entry1,
  output logic         room2,     // space for two more results
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      head
);

  result_t              store [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic [Q_CNT_W-1:0]   count_next;
  logic                 pop;
  logic [Q_CNT_W-1:0]   n_push;

  assign pop       = out_valid && out_ready;
  assign n_push    = Q_CNT_W'(push0) + Q_CNT_W'(push1);
  assign out_valid = (count != '0);
  assign room2     = (count <= Q_CNT_W'(Q_DEPTH - 2));
  assign head      = store[rd_ptr];

  always_comb begin
    count_next = count + n_push - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      store[wr_ptr] <= entry0;
      if (push1) begin
        store[wr_ptr + Q_PTR_W'(1)] <= entry1;
      end
    end else if (push1) begin
      store[wr_ptr] <= entry1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_PTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue holds more entries than it has");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + $past(n_push) - Q_CNT_W'($past(pop)))
    else $error("result queue count lost track of pushes and pops");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push0 && push1) |-> $past(room2) || $past(rst) || room2)
    else $error("two results pushed without room for them");

endmodule

`default_nettype wire

>>> hdl/case_folding_substring_matcher.sv
// Top level of the case-folding substring matcher: configuration, text state and
// match decision. Depends on cfsm_pkg, cfsm_match_unit and cfsm_out_queue.
`default_nettype none

// Usage
//   Text enters on the s_axis channel, one character per beat, with s_axis_tlast
//   on the final character of a text. Results leave on the m_axis channel: a
//   match beat (tlast low) for each reported match, and on the final character a
//   closing beat (tlast high) that says whether any match was seen and where the
//   first one started. Registers are written through the cfg channel, which is
//   always ready; the user must write them only while the block is idle, and
//   the block itself does not enforce this. Latency: results of a character
//   are offered on m_axis in the cycle after its beat if no earlier results
//   wait in the queue. Throughput: one character per cycle; the only limit is
//   the four-entry result queue, which takes a character only while it has
//   room for two results, so a character with a match and closing result costs
//   one extra output beat. When the receiver stalls, results wait in the queue
//   and s_axis_tready falls once fewer than two entries are free; nothing is dropped.
//   Reset (rst, synchronous) restores the register defaults (pattern zero,
//   length one, start position zero, case folding on, first match only), empties
//   the queue and clears the window, position and match summary. The same text
//   state is cleared after every closing result.
module case_folding_substring_matcher import cfsm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int TEXT_MAX    = TEXT_MAX_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Text input
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // [7:0] text_byte
  input  wire logic                 s_axis_tlast,   // text_end
  // Results
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [15:0]               m_axis_tdata,   // [7:0] match_start, [8] found, [15:9] zero
  output logic                      m_axis_tlast,   // closing
  // Register writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);

  localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int POS_W  = $clog2(TEXT_MAX + 1);

  // Configuration registers.
  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_length;
  logic [7:0]  earliest_start;
  logic        fold_case;
  logic        report_all;

  // Text state.
  logic [MAX_PATTERN-1:0][7:0] window;
  logic [MAX_PATTERN-1:0][7:0] window_next;
  logic [POS_W-1:0]            position_count;
  logic [POS_W-1:0]            position_next;
  logic [FILL_W-1:0]           window_fill;
  logic [FILL_W-1:0]           fill_next;
  logic                        any_found;
  logic [7:0]                  first_start;

  logic                        in_beat;
  logic [IDX_W-1:0]            len_m1;
  logic [POS_W-1:0]            match_pos;
  logic                        hit;
  logic                        eligible;
  logic                        emit;
  result_t                     match_res;
  result_t                     close_res;
  logic                        room2;
  result_t                     head;

  assign cfg_ready = 1'b1;
  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = room2;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= 4'd1;
      earliest_start <= '0;
      fold_case      <= 1'b1;
      report_all     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[3:0];
        REG_START_POSITION: earliest_start <= cfg_data[7:0];
        REG_FOLD_CASE:      fold_case      <= cfg_data[0];
        REG_REPORT_ALL:     report_all     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective pattern length minus one: zero counts as one, and lengths beyond
  // the window are cut to the window depth.
  always_comb begin
    if (pattern_length == 4'd0) begin
      len_m1 = '0;
    end else if (32'(pattern_length) > MAX_PATTERN) begin
      len_m1 = IDX_W'(MAX_PATTERN - 1);
    end else begin
      len_m1 = IDX_W'(pattern_length - 4'd1);
    end
  end

  // The new character enters at entry 0 and the oldest drops out.
  always_comb begin
    window_next[0] = s_axis_tdata;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      window_next[i] = window[i-1];
    end
  end

  assign fill_next = (32'(window_fill) < MAX_PATTERN) ? window_fill + FILL_W'(1)
                                                      : window_fill;
  assign position_next = (32'(position_count) < TEXT_MAX) ? position_count + POS_W'(1)
                                                          : position_count;

  // Start of the candidate match ending at the new character.
  assign match_pos = position_count - POS_W'(len_m1);

  cfsm_match_unit #(
    .MAX_PATTERN (MAX_PATTERN),
    .IDX_W       (IDX_W)
  ) u_match (
    .win           (window_next),
    .pattern_bytes (pattern_bytes),
    .len_m1        (len_m1),
    .fold_case     (fold_case),
    .hit           (hit)
  );

  // A match counts only inside the text bound, once enough characters of this
  // text have arrived, and not before the configured start position.
  assign eligible = hit
                 && (32'(position_count) < TEXT_MAX)
                 && (32'(fill_next) > 32'(len_m1))
                 && (32'(match_pos) >= 32'(earliest_start));
  assign emit = eligible && (report_all || !any_found);

  always_comb begin
    match_res.closing     = 1'b0;
    match_res.found       = 1'b1;
    match_res.match_start = 8'(match_pos);
    close_res.closing     = 1'b1;
    close_res.found       = any_found || eligible;
    if (any_found) begin
      close_res.match_start = first_start;
    end else if (eligible) begin
      close_res.match_start = 8'(match_pos);
    end else begin
      close_res.match_start = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window         <= '0;
      position_count <= '0;
      window_fill    <= '0;
      any_found      <= 1'b0;
      first_start    <= '0;
    end else if (in_beat) begin
      if (s_axis_tlast) begin
        // The closing result ends the text; start afresh for the next one.
        window         <= '0;
        position_count <= '0;
        window_fill    <= '0;
        any_found      <= 1'b0;
        first_start    <= '0;
      end else begin
        window         <= window_next;
        position_count <= position_next;
        window_fill    <= fill_next;
        if (eligible && !any_found) begin
          any_found   <= 1'b1;
          first_start <= 8'(match_pos);
        end
      end
    end
  end

  cfsm_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push0     (in_beat && emit),
    .entry0    (match_res),
    .push1     (in_beat && s_axis_tlast),
    .entry1    (close_res),
    .room2     (room2),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .head      (head)
  );

  assign m_axis_tdata = {7'd0, head.found, head.match_start};
  assign m_axis_tlast = head.closing;

  a_text_cleared: assert property (@(posedge clk) disable iff (rst)
    (in_beat && s_axis_tlast) |=> (position_count == '0) && (window_fill == '0)
                                  && !any_found)
    else $error("text state not cleared after the final character");

  a_found_sticky: assert property (@(posedge clk) disable iff (rst)
    $fell(any_found) |-> $past(in_beat && s_axis_tlast) || $past(rst))
    else $error("match summary dropped in the middle of a text");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(window_fill) <= MAX_PATTERN) && (32'(position_count) <= TEXT_MAX))
    else $error("window fill or position passed its bound");

endmodule

`default_nettype wire
